FILE: rtl/srgc_pkg.sv
// ----------------------------------------------------------------------------
// srgc_pkg
// Shared widths, codes and command/status types for the range gap checker.
// ----------------------------------------------------------------------------
package srgc_pkg;

	localparam int unsigned MaxStreamsDef      = 16;
	localparam int unsigned RangesPerStreamDef = 256;
	localparam int unsigned GapTotalW          = 13;
	localparam logic [12:0] GapTotalMax        = 13'h1fff;
	localparam logic [15:0] ThreshReset        = 16'd1;
	localparam logic [15:0] AgeReset           = 16'd60;

	typedef enum logic [1:0] {
		ST_STORED     = 2'd0,
		ST_TABLE_FULL = 2'd1,
		ST_RANGE_FULL = 2'd2,
		ST_CHECK_DONE = 2'd3
	} status_t;

	localparam logic CFG_THRESH = 1'b0;
	localparam logic CFG_AGE    = 1'b1;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,       // capture input word, clear accumulators
		OP_FIND,        // look up the stream slot
		OP_STORE,       // write range at slot's count, bump count
		OP_SLOT_BEGIN,  // load count of current slot, reset per-slot regs
		OP_SORT_RD_KEY, // issue read of key at index i
		OP_SORT_RD_PRV, // issue read of element j-1
		OP_SORT_SHIFT,  // move element j-1 to j, decrement j
		OP_SORT_PUT,    // write key at j, advance i
		OP_WALK_RD,     // issue read at walk index
		OP_WALK_EVAL,   // evaluate walked element
		OP_MOVE_RD,     // issue read at k+m
		OP_MOVE_WR,     // write to m, advance m
		OP_SLOT_END,    // commit count, add gaps, advance slot
		OP_RESULT       // unused; the controller drives done itself
	} op_t;

	typedef struct packed {
		op_t op;
	} srgc_cmd_t;

	typedef struct packed {
		logic is_check;
		logic id_zero;
		logic found;       // slot exists or free slot available
		logic range_full;
		logic slot_used;   // current slot holds a stream id
		logic slot_last;   // current slot is the last one
		logic sort_done;   // i reached count
		logic shift_go;    // j>0 and element j-1 start above key
		logic walk_done;   // walk index reached count
		logic walk_recent; // walked element is recent
		logic move_done;   // k+m reached count
	} srgc_sts_t;

endpackage

FILE: rtl/srgc_ram.sv
// ----------------------------------------------------------------------------
// srgc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module srgc_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

FILE: rtl/srgc_datapath.sv
// ----------------------------------------------------------------------------
// srgc_datapath
// Stream table, range store and arithmetic for store and check words.
// ----------------------------------------------------------------------------
module srgc_datapath import srgc_pkg::*; #(
	parameter int unsigned MaxStreams      = MaxStreamsDef,
	parameter int unsigned RangesPerStream = RangesPerStreamDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  srgc_cmd_t   cmd,
	output srgc_sts_t   sts,
	input  logic        req_type,
	input  logic [31:0] stream_id,
	input  logic [31:0] range_start,
	input  logic [31:0] range_end,
	input  logic [31:0] now_seconds,
	input  logic [15:0] thresh,
	input  logic [15:0] age,
	output logic [1:0]  status,
	output logic [GapTotalW-1:0] gap_total,
	output logic        gap_alarm
);
	localparam int unsigned SW = (MaxStreams > 1) ? $clog2(MaxStreams) : 1;
	localparam int unsigned CW = $clog2(RangesPerStream + 1);
	localparam int unsigned Depth = MaxStreams * RangesPerStream;
	localparam int unsigned AW = $clog2(Depth);
	localparam int unsigned EW = 96;
	// Total gaps stay below Depth; keep at least 17 bits for the threshold compare.
	localparam int unsigned TW = (AW + 1 > 17) ? AW + 1 : 17;

	logic [31:0] ids_q  [MaxStreams];
	logic [CW-1:0] cnt_q [MaxStreams];

	logic        req_q;
	logic [31:0] id_q, rs_q, re_q, now_q;
	logic [SW-1:0] slot_q;
	logic        found_q, full_q;
	logic [CW-1:0] n_q, i_q, j_q, k_q, m_q;
	logic [EW-1:0] key_q;
	logic [31:0] prev_q;
	logic [CW-1:0] sgaps_q;
	logic [TW-1:0] total_q;
	logic [32:0] limit_q;

	// RAM port
	logic          we;
	logic [AW-1:0] addr;
	logic [EW-1:0] wdata, rdata;

	srgc_ram #(.Width(EW), .Depth(Depth)) u_store (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	function automatic logic [AW-1:0] at(input logic [SW-1:0] s, input logic [CW-1:0] x);
		return AW'(s) * AW'(RangesPerStream) + AW'(x);
	endfunction

	// Slot search: first free or matching slot, priority on lowest.
	logic [SW-1:0] hit_slot;
	logic          hit;
	always_comb begin
		hit_slot = '0;
		hit = 1'b0;
		for (int s = MaxStreams - 1; s >= 0; s--) begin
			if (ids_q[s] == '0 || ids_q[s] == id_q) begin
				hit_slot = SW'(s);
				hit = 1'b1;
			end
		end
	end

	always_comb begin
		we = 1'b0;
		addr = at(slot_q, i_q);
		wdata = key_q;
		case (cmd.op)
			OP_STORE: begin
				we = 1'b1;
				addr = at(slot_q, cnt_q[slot_q]);
				wdata = {rs_q, re_q, now_q};
			end
			OP_SORT_RD_KEY: addr = at(slot_q, i_q);
			OP_SORT_RD_PRV: addr = at(slot_q, j_q - CW'(1));
			OP_SORT_SHIFT: begin
				we = 1'b1;
				addr = at(slot_q, j_q);
				wdata = rdata;
			end
			OP_SORT_PUT: begin
				we = 1'b1;
				addr = at(slot_q, j_q);
				wdata = key_q;
			end
			OP_WALK_RD: addr = at(slot_q, k_q);
			OP_MOVE_RD: addr = at(slot_q, k_q + m_q);
			OP_MOVE_WR: begin
				we = 1'b1;
				addr = at(slot_q, m_q);
				wdata = rdata;
			end
			default: ;
		endcase
	end

	logic [32:0] rtime;
	assign rtime = {1'b0, rdata[31:0]};

	always_comb begin
		sts.is_check    = req_q;
		sts.id_zero     = (id_q == '0);
		sts.found       = found_q;
		sts.range_full  = full_q;
		sts.slot_used   = (ids_q[slot_q] != '0);
		sts.slot_last   = (slot_q == SW'(MaxStreams - 1));
		sts.sort_done   = (i_q >= n_q);
		sts.shift_go    = (j_q != '0) && (rdata[95:64] > key_q[95:64]);
		sts.walk_done   = (k_q >= n_q);
		sts.walk_recent = limit_q[32] || ($signed({1'b0, rtime}) > $signed({1'b0, limit_q}));
		sts.move_done   = ((k_q + m_q) >= n_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MaxStreams; s++) begin
				ids_q[s] <= '0;
				cnt_q[s] <= '0;
			end
			slot_q  <= '0;
			req_q   <= 1'b0;
			id_q    <= '0;
			rs_q    <= '0;
			re_q    <= '0;
			now_q   <= '0;
			limit_q <= '0;
			total_q <= '0;
			found_q <= 1'b0;
			full_q  <= 1'b0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			m_q     <= '0;
			key_q   <= '0;
			prev_q  <= '0;
			sgaps_q <= '0;
		end else begin
			case (cmd.op)
				OP_LATCH: begin
					req_q   <= req_type;
					id_q    <= stream_id;
					rs_q    <= range_start;
					re_q    <= range_end;
					now_q   <= now_seconds;
					limit_q <= {1'b0, now_seconds} - {17'd0, age};
					slot_q  <= '0;
					total_q <= '0;
				end
				OP_FIND: begin
					slot_q  <= hit_slot;
					found_q <= hit;
					full_q  <= (cnt_q[hit_slot] >= CW'(RangesPerStream));
				end
				OP_STORE: begin
					ids_q[slot_q] <= id_q;
					cnt_q[slot_q] <= cnt_q[slot_q] + CW'(1);
				end
				OP_SLOT_BEGIN: begin
					n_q <= cnt_q[slot_q];
					i_q <= CW'(1);
					k_q <= '0;
					m_q <= '0;
					prev_q <= '0;
					sgaps_q <= '0;
				end
				OP_SORT_RD_KEY: j_q <= i_q;
				OP_SORT_RD_PRV: if (j_q == i_q) key_q <= rdata;
				OP_SORT_SHIFT: j_q <= j_q - CW'(1);
				OP_SORT_PUT: i_q <= i_q + CW'(1);
				OP_WALK_EVAL: begin
					if (!sts.walk_recent) begin
						if (prev_q != '0 && prev_q != rdata[95:64])
							sgaps_q <= sgaps_q + CW'(1);
						prev_q <= rdata[63:32];
						k_q <= k_q + CW'(1);
					end
				end
				OP_MOVE_WR: m_q <= m_q + CW'(1);
				OP_SLOT_END: begin
					cnt_q[slot_q] <= m_q;
					total_q <= total_q + TW'(sgaps_q);
					slot_q <= slot_q + SW'(1);
				end
				default: ;
			endcase
		end
	end

	// Result word; the controller strobes done alongside it.
	always_comb begin
		status = ST_STORED;
		gap_total = '0;
		gap_alarm = 1'b0;
		if (req_q) begin
			status = ST_CHECK_DONE;
			gap_total = (total_q > TW'(GapTotalMax)) ? GapTotalMax : total_q[GapTotalW-1:0];
			gap_alarm = (total_q >= TW'(thresh));
		end else if (id_q == '0 || !found_q) begin
			status = ST_TABLE_FULL;
		end else if (full_q) begin
			status = ST_RANGE_FULL;
		end
	end
endmodule

FILE: rtl/srgc_ctrl.sv
// ----------------------------------------------------------------------------
// srgc_ctrl
// Sequencer for store and check words.
// ----------------------------------------------------------------------------
module srgc_ctrl import srgc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output srgc_cmd_t cmd,
	input  srgc_sts_t sts
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_FIND, S_STORE, S_SLOT, S_KEY, S_PRV, S_CMP,
		S_PUT, S_WRD, S_WEV, S_MRD, S_MWR, S_END, S_RES
	} state_t;
	state_t state_q;

	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:   if (start) cmd.op = OP_LATCH;
			S_DECODE: if (!sts.is_check) cmd.op = OP_FIND;
			S_FIND:   if (!sts.id_zero && sts.found && !sts.range_full) cmd.op = OP_STORE;
			S_STORE:  ;
			S_SLOT:   if (sts.slot_used) cmd.op = OP_SLOT_BEGIN;
			S_KEY:    if (!sts.sort_done) cmd.op = OP_SORT_RD_KEY;
			S_PRV:    cmd.op = OP_SORT_RD_PRV;
			S_CMP:    cmd.op = sts.shift_go ? OP_SORT_SHIFT : OP_SORT_PUT;
			S_PUT:    ;
			S_WRD:    if (!sts.walk_done) cmd.op = OP_WALK_RD;
			S_WEV:    cmd.op = OP_WALK_EVAL;
			S_MRD:    if (!sts.move_done) cmd.op = OP_MOVE_RD;
			S_MWR:    cmd.op = OP_MOVE_WR;
			S_END:    cmd.op = OP_SLOT_END;
			S_RES:    ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_DECODE;
					busy <= 1'b1;
				end
				S_DECODE: state_q <= sts.is_check ? S_SLOT : S_FIND;
				S_FIND: begin
					state_q <= S_RES;
					done <= 1'b1;
				end
				S_STORE: state_q <= S_RES;
				S_SLOT: begin
					if (!sts.slot_used) begin
						state_q <= S_RES;
						done <= 1'b1;
					end else state_q <= S_KEY;
				end
				S_KEY:  state_q <= sts.sort_done ? S_WRD : S_PRV;
				S_PRV:  state_q <= S_CMP;
				// after shift, re-read previous element
				S_CMP:  state_q <= sts.shift_go ? S_PRV : S_PUT;
				S_PUT:  state_q <= S_KEY;
				S_WRD:  state_q <= sts.walk_done ? S_MRD : S_WEV;
				S_WEV:  state_q <= sts.walk_recent ? S_MRD : S_WRD;
				S_MRD:  state_q <= sts.move_done ? S_END : S_MWR;
				S_MWR:  state_q <= S_MRD;
				S_END: begin
					if (sts.slot_last) begin
						state_q <= S_RES;
						done <= 1'b1;
					end else state_q <= S_SLOT;
				end
				S_RES: begin
					state_q <= S_IDLE;
					busy <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/sequence_range_gap_checker_core.sv
// ----------------------------------------------------------------------------
// sequence_range_gap_checker_core
// Per-stream sequence range store with periodic gap check.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A store word goes
// from start to the result strobe through the accept cycle, decode, slot
// lookup with the write into the single-port range memory, and the result
// cycle; busy drops after the strobe, so the next word is taken only then.
// A check word walks every used slot through the same memory port: per slot
// an insertion sort that reads each element after the first and shifts
// larger ones up, then a read and evaluation per walked range and a read
// and write per retained range, plus slot overhead. The check also has the
// accept, decode and result cycles, and a visit to the free slot that ends
// the scan, if any. The result is on status, gap_total and gap_alarm for
// exactly one cycle with done high; the receiver cannot stall it, so take it then.
// Memory entries need no clearing pass: only entries below a slot count
// are ever read. Write configuration only while busy is low.
// ----------------------------------------------------------------------------
module sequence_range_gap_checker_core import srgc_pkg::*; #(
	parameter int unsigned MaxStreams      = MaxStreamsDef,
	parameter int unsigned RangesPerStream = RangesPerStreamDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [31:0] stream_id,
	input  logic [31:0] range_start,
	input  logic [31:0] range_end,
	input  logic [31:0] now_seconds,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [GapTotalW-1:0] gap_total,
	output logic        gap_alarm
);
	srgc_cmd_t cmd;
	srgc_sts_t sts;
	logic [15:0] thresh_q, age_q;
	logic [1:0] st;
	logic [GapTotalW-1:0] gt;
	logic ga;

	// Configuration is always ready; hold values until rewritten.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= ThreshReset;
			age_q    <= AgeReset;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_THRESH) thresh_q <= cfg_data;
			else age_q <= cfg_data;
		end
	end

	srgc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cmd(cmd), .sts(sts)
	);

	srgc_datapath #(.MaxStreams(MaxStreams), .RangesPerStream(RangesPerStream)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(req_type), .stream_id(stream_id), .range_start(range_start),
		.range_end(range_end), .now_seconds(now_seconds),
		.thresh(thresh_q), .age(age_q),
		.status(st), .gap_total(gt), .gap_alarm(ga)
	);

	// Result fields are meaningful only while done is high.
	assign status    = st;
	assign gap_total = gt;
	assign gap_alarm = ga;
endmodule
